// ----- rtl/psp_pkg.sv -----
// ----------------------------------------------------------------------------
// psp_pkg
// Shared types and constants of the pulse period speedometer.
// ----------------------------------------------------------------------------
`default_nettype none

package psp_pkg;

  // defaults of the top level parameters
  localparam int DEFAULT_AVERAGE_LOG2        = 4;
  localparam int DEFAULT_SPEED_FRACTION_BITS = 0;

  // register reset values
  localparam logic [15:0] PULSES_PER_KM_RESET = 16'd6000;
  localparam logic [15:0] MIN_PERIOD_RESET    = 16'd830;

  // register index, taken from byte address bit 2
  localparam logic REG_PULSES_PER_KM = 1'b0;
  localparam logic REG_MIN_PERIOD    = 1'b1;

  // event kinds
  localparam logic KIND_CAPTURE  = 1'b0;
  localparam logic KIND_OVERFLOW = 1'b1;

  // arithmetic constants
  localparam logic [15:0] PERIOD_EMPTY  = 16'hFFFF;
  localparam logic [15:0] SPEED_CUTOFF  = 16'd65435;
  localparam logic [15:0] SPEED_MAX     = 16'hFFFF;
  localparam int          SPEED_SCALE   = 25;
  localparam int          METERS_PER_KM = 1000;

  // width of 25 * pulses_per_km and of pulse_counter * 1000
  localparam int SCALE_PROD_W = 21;
  localparam int DIST_PROD_W  = 26;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_MEAN,
    ST_DECIDE,
    ST_SPD_DIV,
    ST_DST_START,
    ST_DST_DIV,
    ST_WAIT_OUT
  } state_t;

endpackage

`default_nettype wire

// ----- rtl/pulse_period_speedometer.sv -----
// ----------------------------------------------------------------------------
// pulse_period_speedometer
// Wheel sensor speedometer and odometer: trimmed mean of recent pulse
// periods turned into speed, pulse count turned into distance.
// ----------------------------------------------------------------------------
//
//  channel   dir  beat contents
//  s_axis    in   tuser[0] kind, tdata[15:0] period_ticks
//  m_axis    out  tdata[15:0] speed, tdata[47:16] distance_m
//  apb       in   0x0 pulses_per_km, 0x4 min_period
//
//  When both divisions run, the ring is read one entry a cycle through its
//  memory port, then the shared divider spends one cycle per quotient bit for
//  speed and distance. A mean at or above the cutoff or zero skips the speed
//  division, and zero pulses_per_km skips the distance division.
//  Reset clears the entry valid bits at once, so the ring reads as empty
//  from the first cycle; there is no clearing pass, and no beat is taken
//  while reset is high.
//  A new event is taken while the previous result still waits in the
//  output register; a stalled output holds the sequencer before its load.
//
`default_nettype none

module pulse_period_speedometer
  import psp_pkg::*;
#(
  parameter int AVERAGE_LOG2        = DEFAULT_AVERAGE_LOG2,
  parameter int SPEED_FRACTION_BITS = DEFAULT_SPEED_FRACTION_BITS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // input stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // [15:0] period_ticks
  input  wire logic        s_axis_tuser,   // [0] kind
  // output stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata,   // [15:0] speed, [47:16] distance_m
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int DEPTH  = (1 << AVERAGE_LOG2) + 4;
  localparam int AW     = $clog2(DEPTH);
  localparam int NUM_W  = SCALE_PROD_W + SPEED_FRACTION_BITS;
  localparam int DIV_W  = (NUM_W > DIST_PROD_W) ? NUM_W : DIST_PROD_W;

  state_t state;
  state_t state_next;

  logic [15:0]    pulses_per_km;
  logic [15:0]    min_period;
  logic [15:0]    pulse_counter;
  logic [31:0]    whole_distance;
  logic [AW-1:0]  scan_addr;
  logic [15:0]    mean_reg;
  logic [15:0]    speed;
  logic [31:0]    distance_m;
  logic [15:0]    pulse_count_inc;

  logic           accept;
  logic           push;
  logic           fill;
  logic           cfg_write;
  logic           load_out;
  logic           scan_en;
  logic           trim_clear;
  logic [15:0]    ring_data;
  logic           ring_valid;
  logic [15:0]    trim_mean;

  logic [SCALE_PROD_W-1:0] scale_prod;
  logic [NUM_W-1:0]        numerator;
  logic [DIST_PROD_W-1:0]  dist_prod;
  logic                    div_start;
  logic [DIV_W-1:0]        div_dividend;
  logic [15:0]             div_divisor;
  logic                    div_done;
  logic [DIV_W-1:0]        div_quo;

  // configuration registers
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pulses_per_km <= PULSES_PER_KM_RESET;
      min_period    <= MIN_PERIOD_RESET;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_PULSES_PER_KM: pulses_per_km <= pwdata[15:0];
        REG_MIN_PERIOD:    min_period    <= pwdata[15:0];
        default:           ;
      endcase
    end
  end

  assign prdata = (paddr[2] == REG_MIN_PERIOD) ? {16'd0, min_period} : {16'd0, pulses_per_km};

  // input beat decode
  assign s_axis_tready = (state == ST_IDLE) && !rst;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign push          = accept && (s_axis_tuser == KIND_CAPTURE) && (s_axis_tdata > min_period);
  assign fill          = accept && (s_axis_tuser == KIND_OVERFLOW);
  assign trim_clear    = accept;
  assign scan_en       = (state == ST_SCAN);

  // pulse counter and whole kilometers
  assign pulse_count_inc = pulse_counter + 16'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_counter  <= '0;
      whole_distance <= '0;
    end else if (accept && (s_axis_tuser == KIND_CAPTURE)) begin
      if (pulse_count_inc >= pulses_per_km) begin
        pulse_counter  <= '0;
        whole_distance <= whole_distance + 32'(METERS_PER_KM);
      end else begin
        pulse_counter <= pulse_count_inc;
      end
    end
  end

  // ring memory and scan statistics
  psp_ring #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ring (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (s_axis_tdata),
    .fill      (fill),
    .rd_en     (scan_en),
    .rd_addr   (scan_addr),
    .rd_data   (ring_data),
    .rd_valid  (ring_valid)
  );

  psp_trim #(
    .AVERAGE_LOG2 (AVERAGE_LOG2),
    .SUM_W        (16 + $clog2(DEPTH))
  ) u_trim (
    .clk      (clk),
    .clear    (trim_clear),
    .in_valid (ring_valid),
    .in_data  (ring_data),
    .mean     (trim_mean)
  );

  // divider operands
  assign scale_prod   = SCALE_PROD_W'(pulses_per_km) * SCALE_PROD_W'(SPEED_SCALE);
  assign numerator    = NUM_W'(scale_prod) << SPEED_FRACTION_BITS;
  assign dist_prod    = DIST_PROD_W'(pulse_counter) * DIST_PROD_W'(METERS_PER_KM);
  assign div_dividend = (state == ST_DECIDE) ? DIV_W'(numerator) : DIV_W'(dist_prod);
  assign div_divisor  = (state == ST_DECIDE) ? mean_reg : pulses_per_km;

  psp_divider #(
    .NW (DIV_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  // sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequencer next state and strobes
  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_addr == AW'(DEPTH - 1)) state_next = ST_DRAIN;
      end
      ST_DRAIN: state_next = ST_MEAN;
      ST_MEAN:  state_next = ST_DECIDE;
      ST_DECIDE: begin
        if ((mean_reg >= SPEED_CUTOFF) || (mean_reg == 16'd0)) begin
          state_next = ST_DST_START;
        end else begin
          div_start  = 1'b1;
          state_next = ST_SPD_DIV;
        end
      end
      ST_SPD_DIV: begin
        if (div_done) state_next = ST_DST_START;
      end
      ST_DST_START: begin
        if (pulses_per_km == 16'd0) begin
          state_next = ST_WAIT_OUT;
        end else begin
          div_start  = 1'b1;
          state_next = ST_DST_DIV;
        end
      end
      ST_DST_DIV: begin
        if (div_done) state_next = ST_WAIT_OUT;
      end
      ST_WAIT_OUT: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // scan address
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_addr <= '0;
    end else if (accept) begin
      scan_addr <= '0;
    end else if (scan_en && (scan_addr != AW'(DEPTH - 1))) begin
      scan_addr <= scan_addr + 1'b1;
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (state == ST_MEAN) begin
      mean_reg <= trim_mean;
    end
    if (state == ST_DECIDE) begin
      if (mean_reg >= SPEED_CUTOFF) begin
        speed <= '0;
      end else if (mean_reg == 16'd0) begin
        speed <= (numerator != '0) ? SPEED_MAX : 16'd0;
      end
    end
    if ((state == ST_SPD_DIV) && div_done) begin
      speed <= (|div_quo[DIV_W-1:16]) ? SPEED_MAX : div_quo[15:0];
    end
    if ((state == ST_DST_START) && (pulses_per_km == 16'd0)) begin
      distance_m <= whole_distance;
    end
    if ((state == ST_DST_DIV) && div_done) begin
      distance_m <= whole_distance + 32'(div_quo);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (load_out) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_axis_tdata <= {distance_m, speed};
    end
  end

  // checks
  a_accept_starts_scan: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_SCAN))
    else $error("accepted beat did not start a ring scan");

  a_div_done_in_div_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> ((state == ST_SPD_DIV) || (state == ST_DST_DIV)))
    else $error("divider finished outside a divide state");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    scan_en |-> (int'(scan_addr) < DEPTH))
    else $error("ring scan address beyond depth");

  a_load_slot_free: assert property (@(posedge clk) disable iff (rst)
    load_out |-> (!m_axis_tvalid || m_axis_tready))
    else $error("output register overwritten while a beat waits");

  a_scan_reads_back: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DRAIN) |-> ring_valid)
    else $error("last ring read missing during drain");

endmodule

`default_nettype wire

// ----- rtl/psp_ring.sv -----
// ----------------------------------------------------------------------------
// psp_ring
// Ring of recent periods in a synchronous memory, with one valid bit per
// entry so that reset and timer overflow refill the whole ring at once.
// ----------------------------------------------------------------------------
`default_nettype none

module psp_ring
  import psp_pkg::*;
#(
  parameter int DEPTH = 20,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire logic [15:0]   push_data,
  input  wire logic          fill,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic [15:0]        rd_data,
  output logic               rd_valid
);

  logic [15:0]      mem [DEPTH];
  logic [DEPTH-1:0] valid;
  logic [AW-1:0]    write_index;
  logic [15:0]      mem_q;
  logic             valid_q;

  // write port
  always_ff @(posedge clk) begin
    if (push) begin
      mem[write_index] <= push_data;
    end
  end

  // valid bits and write pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      valid       <= '0;
      write_index <= '0;
    end else if (fill) begin
      valid <= '0;
    end else if (push) begin
      valid[write_index] <= 1'b1;
      if (write_index == AW'(DEPTH - 1)) begin
        write_index <= '0;
      end else begin
        write_index <= write_index + 1'b1;
      end
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q   <= mem[rd_addr];
      valid_q <= valid[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= rd_en;
    end
  end

  // an entry never written since the last fill reads as empty
  assign rd_data = valid_q ? mem_q : PERIOD_EMPTY;

endmodule

`default_nettype wire

// ----- rtl/psp_trim.sv -----
// ----------------------------------------------------------------------------
// psp_trim
// Accumulates the ring beats of one scan: running sum, two largest and two
// smallest values. Gives the mean with those four dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module psp_trim
  import psp_pkg::*;
#(
  parameter int AVERAGE_LOG2 = 4,
  parameter int SUM_W        = 16 + $clog2((1 << AVERAGE_LOG2) + 4)
) (
  input  wire logic        clk,
  input  wire logic        clear,
  input  wire logic        in_valid,
  input  wire logic [15:0] in_data,
  output logic [15:0]      mean
);

  logic [SUM_W-1:0] sum;
  logic [15:0]      max1;
  logic [15:0]      max2;
  logic [15:0]      min1;
  logic [15:0]      min2;
  logic [SUM_W-1:0] trimmed;

  // running statistics
  always_ff @(posedge clk) begin
    if (clear) begin
      sum  <= '0;
      max1 <= '0;
      max2 <= '0;
      min1 <= PERIOD_EMPTY;
      min2 <= PERIOD_EMPTY;
    end else if (in_valid) begin
      sum <= sum + SUM_W'(in_data);
      if (in_data > max1) begin
        max2 <= max1;
        max1 <= in_data;
      end else if (in_data > max2) begin
        max2 <= in_data;
      end
      if (in_data < min1) begin
        min2 <= min1;
        min1 <= in_data;
      end else if (in_data < min2) begin
        min2 <= in_data;
      end
    end
  end

  // drop the extremes and scale down
  assign trimmed = sum - (SUM_W'(max1) + SUM_W'(max2)) - (SUM_W'(min1) + SUM_W'(min2));
  assign mean    = 16'(trimmed >> AVERAGE_LOG2);

endmodule

`default_nettype wire

// ----- rtl/psp_divider.sv -----
// ----------------------------------------------------------------------------
// psp_divider
// Restoring divider, one quotient bit per cycle, shared by speed and
// distance.
// ----------------------------------------------------------------------------
`default_nettype none

module psp_divider
  import psp_pkg::*;
#(
  parameter int NW = 29
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [NW-1:0] dividend,
  input  wire logic [15:0]   divisor,
  output logic               done,
  output logic [NW-1:0]      quotient
);

  localparam int CW = $clog2(NW + 1);

  logic          busy;
  logic [CW-1:0] count;
  logic [16:0]   rem;
  logic [15:0]   dsr;
  logic [NW-1:0] quo;
  logic [16:0]   rem_shift;
  logic          take;

  // one trial subtraction
  assign rem_shift = {rem[15:0], quo[NW-1]};
  assign take      = rem_shift >= {1'b0, dsr};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CW'(NW);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dsr <= divisor;
      quo <= dividend;
    end else if (busy) begin
      rem <= take ? rem_shift - {1'b0, dsr} : rem_shift;
      quo <= {quo[NW-2:0], take};
    end
  end

  assign quotient = quo;

endmodule

`default_nettype wire

// ----- tb/pulse_period_speedometer_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pulse_period_speedometer_tb
// Self-checking bench for the wheel sensor speedometer and odometer. Wheel
// events are streamed in with random gaps, every output beat is compared with
// an in-bench prediction of speed and distance, and the two registers are
// rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------

module pulse_period_speedometer_tb;
  import psp_pkg::*;

  localparam int AVG_LOG2    = DEFAULT_AVERAGE_LOG2;
  localparam int FRAC_BITS   = DEFAULT_SPEED_FRACTION_BITS;
  localparam int RING_DEPTH  = (1 << AVG_LOG2) + 4;
  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_WAIT  = 200;

  typedef struct packed {
    logic        kind;
    logic [15:0] period;
  } wheel_beat_t;

  typedef struct packed {
    logic [15:0] speed;
    logic [31:0] distance;
  } reading_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;   // [15:0] period_ticks
  logic        s_axis_tuser = 1'b0; // [0] kind
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;        // [15:0] speed, [47:16] distance_m
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  pulse_period_speedometer #(
    .AVERAGE_LOG2       (AVG_LOG2),
    .SPEED_FRACTION_BITS(FRAC_BITS)
  ) uut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #6 clk = ~clk;

  // predicted state of the speedometer
  logic [15:0] ring_q [RING_DEPTH];
  int unsigned wr_ptr;
  logic [15:0] pulse_cnt;
  logic [31:0] km_meters;
  logic [15:0] ppk_q;
  logic [15:0] minp_q;

  wheel_beat_t beats_pending [$];
  reading_t    readings_due [$];
  int          beats_queued = 0;
  int          beats_taken = 0;
  int          failures = 0;
  int          cycle_count = 0;

  logic        in_fire = 1'b0;
  logic        out_fire = 1'b0;
  int          in_gap = 0;
  int          out_gap = 0;
  bit          in_steady = 1'b0;
  bit          out_steady = 1'b0;
  wheel_beat_t next_beat;
  reading_t    want;

  // trimmed mean of the ring: two largest and two smallest positions dropped
  function automatic logic [15:0] ring_speed();
    bit          taken [RING_DEPTH];
    int          i;
    int          k;
    int          best;
    logic [31:0] total;
    logic [31:0] mean;
    logic [63:0] num;
    logic [63:0] quo;
    total = '0;
    for (i = 0; i < RING_DEPTH; i++) taken[i] = 1'b0;
    for (k = 0; k < 4; k++) begin
      best = -1;
      for (i = 0; i < RING_DEPTH; i++) begin
        if (taken[i]) continue;
        if (best < 0) best = i;
        else if (k < 2 ? ring_q[i] > ring_q[best] : ring_q[i] < ring_q[best]) best = i;
      end
      if (best >= 0) taken[best] = 1'b1;
    end
    for (i = 0; i < RING_DEPTH; i++)
      if (!taken[i]) total += ring_q[i];
    mean = total >> AVG_LOG2;
    if (mean >= SPEED_CUTOFF) return '0;
    num = (64'(SPEED_SCALE) * ppk_q) << FRAC_BITS;
    if (mean == 0) return (num != 0) ? SPEED_MAX : 16'd0;
    quo = num / mean;
    return (quo > SPEED_MAX) ? SPEED_MAX : quo[15:0];
  endfunction

  // apply one wheel event to the predicted state and return the reading
  function automatic reading_t wheel_event(input logic kind, input logic [15:0] period);
    reading_t    r;
    logic [31:0] part;
    int          i;
    if (kind == KIND_CAPTURE) begin
      if (period > minp_q) begin
        if (wr_ptr >= RING_DEPTH) wr_ptr = 0;
        ring_q[wr_ptr] = period;
        wr_ptr++;
        if (wr_ptr >= RING_DEPTH) wr_ptr = 0;
      end
      pulse_cnt = pulse_cnt + 16'd1;
      if (pulse_cnt >= ppk_q) begin
        pulse_cnt = '0;
        km_meters = km_meters + METERS_PER_KM;
      end
    end else begin
      for (i = 0; i < RING_DEPTH; i++) ring_q[i] = PERIOD_EMPTY;
    end
    part = '0;
    if (ppk_q != 0) part = (32'(pulse_cnt) * METERS_PER_KM) / ppk_q;
    r.speed = ring_speed();
    r.distance = km_meters + part;
    return r;
  endfunction

  // input driver: one beat at a time, random gap after each accepted beat
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_fire) begin
      if (in_fire) begin
        if ($urandom_range(0, 29) == 0) in_steady = !in_steady;
        in_gap = in_steady ? 0 : $urandom_range(0, 8);
      end
      if (in_gap > 0) begin
        in_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (beats_pending.size() > 0) begin
        next_beat = beats_pending.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= next_beat.kind;
        s_axis_tdata <= next_beat.period;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // output back-pressure: random stall after each accepted result beat
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (out_fire) begin
        if ($urandom_range(0, 29) == 0) out_steady = !out_steady;
        out_gap = out_steady ? 0 : $urandom_range(0, 8);
      end
      if (out_gap > 0) begin
        out_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // check result beats, predict accepted input beats
  always @(posedge clk) begin
    in_fire <= s_axis_tvalid && s_axis_tready;
    out_fire <= m_axis_tvalid && m_axis_tready;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (readings_due.size() == 0) begin
        $error("unexpected result beat: speed %0d distance_m %0d",
               m_axis_tdata[15:0], m_axis_tdata[47:16]);
        failures++;
      end else begin
        want = readings_due.pop_front();
        if (m_axis_tdata[15:0] !== want.speed) begin
          $error("speed mismatch: expected %0d, actual %0d", want.speed, m_axis_tdata[15:0]);
          failures++;
        end
        if (m_axis_tdata[47:16] !== want.distance) begin
          $error("distance_m mismatch: expected %0d, actual %0d",
                 want.distance, m_axis_tdata[47:16]);
          failures++;
        end
      end
    end
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      readings_due.push_back(wheel_event(s_axis_tuser, s_axis_tdata));
      beats_taken++;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic queue_beat(input logic kind, input logic [15:0] period);
    wheel_beat_t b;
    b.kind = kind;
    b.period = period;
    beats_pending.push_back(b);
    beats_queued++;
  endtask

  // block is idle once every queued beat went in and every reading came out
  task automatic wait_drained();
    while (beats_taken != beats_queued || readings_due.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {16'd0, value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == REG_PULSES_PER_KM) ppk_q = value;
    else minp_q = value;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // one setting of both registers, then an overflow and random wheel events;
  // most periods sit in a band so the ring fills and speed is nonzero
  task automatic run_phase(input logic [15:0] ppk, input logic [15:0] minp,
                           input int lo, input int span, input int count);
    int i;
    int p;
    wait_drained();
    write_reg(REG_PULSES_PER_KM, ppk);
    write_reg(REG_MIN_PERIOD, minp);
    queue_beat(KIND_OVERFLOW, 16'($urandom));
    for (i = 0; i < count; i++) begin
      case ($urandom_range(0, 99)) inside
        [0:3]: begin
          queue_beat(KIND_OVERFLOW, 16'($urandom));
        end
        [4:71]: begin
          p = lo + $urandom_range(0, span);
          if (p > 65535) p = 65535;
          queue_beat(KIND_CAPTURE, 16'(p));
        end
        [72:87]: begin
          queue_beat(KIND_CAPTURE, 16'($urandom_range(0, 65535)));
        end
        default: begin
          case ($urandom_range(0, 5))
            0: p = 0;
            1: p = 1;
            2: p = minp;
            3: p = (minp == 16'hFFFF) ? 65535 : minp + 1;
            4: p = 65534;
            default: p = 65535;
          endcase
          queue_beat(KIND_CAPTURE, 16'(p));
        end
      endcase
    end
  endtask

  initial begin
    int i;
    int mp;
    for (i = 0; i < RING_DEPTH; i++) ring_q[i] = PERIOD_EMPTY;
    wr_ptr = 0;
    pulse_cnt = '0;
    km_meters = '0;
    ppk_q = PULSES_PER_KM_RESET;
    minp_q = MIN_PERIOD_RESET;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: reset settings, rejected and accepted periods, full ring, overflow
    queue_beat(KIND_OVERFLOW, 16'hFFFF);
    queue_beat(KIND_CAPTURE, 16'd0);
    queue_beat(KIND_CAPTURE, MIN_PERIOD_RESET);
    queue_beat(KIND_CAPTURE, MIN_PERIOD_RESET + 16'd1);
    queue_beat(KIND_CAPTURE, 16'hFFFF);
    queue_beat(KIND_CAPTURE, 16'hFFFE);
    for (i = 0; i < 16; i++) queue_beat(KIND_CAPTURE, 16'(1000 + 37 * i));
    queue_beat(KIND_CAPTURE, 16'hFFFF);
    queue_beat(KIND_OVERFLOW, 16'd0);
    queue_beat(KIND_CAPTURE, 16'd1);

    // every pulse a whole km, with tiny periods
    run_phase(16'd1, 16'd0, 1, 40, 100);
    // nothing enters the ring at the top min_period
    run_phase(16'hFFFF, 16'hFFFF, 1, 65534, 80);
    // zero pulses per km: speed 0, km per pulse
    run_phase(16'd0, 16'd500, 501, 2000, 80);
    // build up the pulse counter, then drop the setting below it
    run_phase(16'd6000, 16'd830, 900, 3000, 60);
    run_phase(16'd20, 16'd830, 831, 5000, 100);
    // mean straddling the speed cutoff
    run_phase(16'd6000, 16'd830, 65380, 155, 100);
    // random settings
    for (i = 0; i < 5; i++) begin
      mp = $urandom_range(0, 3000);
      run_phase(16'($urandom_range(1, 65535)), 16'(mp),
                $urandom_range(mp + 1, 20000), $urandom_range(0, 4000), 100);
    end
    // back to reset settings
    run_phase(PULSES_PER_KM_RESET, MIN_PERIOD_RESET, 900, 2000, 100);

    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
